// ===== src/pqrr_pkg.sv =====
// ----------------------------------------------------------------------------
// pqrr_pkg: shared types and codes of the round-robin scheduler
// Operation, status and run-state codes, configuration indexes and reset
// values, sequencer states and the write strobes of the slot table.
// ----------------------------------------------------------------------------
package pqrr_pkg;

    // operation codes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_TOGGLE = 3'd3;
    localparam logic [2:0] OP_SETPRI = 3'd4;
    localparam logic [2:0] OP_EXIT   = 3'd5;

    // status codes
    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_NOTFOUND = 3'd1;
    localparam logic [2:0] STS_FULL     = 3'd2;
    localparam logic [2:0] STS_BADPRI   = 3'd3;
    localparam logic [2:0] STS_NOREADY  = 3'd4;

    // run states of a slot
    localparam logic [1:0] RS_READY   = 2'd0;
    localparam logic [1:0] RS_BLOCKED = 2'd1;
    localparam logic [1:0] RS_RUNNING = 2'd2;

    // configuration register indexes
    localparam logic CFG_AGING = 1'b0;
    localparam logic CFG_MAXPRI = 1'b1;

    localparam int AGING_RESET = 90;
    localparam int MAXPRI_RESET = 5;

    typedef enum logic [4:0] {
        S_IDLE,
        S_TICK,
        S_AGE,
        S_SCAN,
        S_STEP,
        S_FIND,
        S_UNLINK,
        S_XPAR,
        S_XPRED,
        S_XRD,
        S_XUNL,
        S_FREE,
        S_ADDRC,
        S_ADDRS,
        S_ADDWC,
        S_FIN
    } seq_state_t;

    // write strobes of the slot table, all at one address
    typedef struct packed {
        logic pid;
        logic parent;
        logic state;
        logic prio;
        logic turns;
        logic next;
        logic set_valid;
        logic clr_valid;
    } slot_wr_t;

endpackage

// ===== src/priority_quantum_round_robin_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_quantum_round_robin_scheduler: ring scheduler of process slots
// Takes one scheduling operation per input beat and returns one result beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries op, pid, parent_id,
//   foreground and new_priority. in_stall is high while an operation is in
//   work; one operation is taken at a time.
//   Output channel (out_valid / out_stall) returns status, running_pid,
//   running_slot and switched, one beat per operation, held while stalled.
//   Configuration: cfg_wr_en writes cfg_wdata to register cfg_index
//   (0 aging_quanta, 1 max_priority). The user must write only while the
//   block is idle; the block itself does not enforce it.
//   The slot table has a single address port, so each walk along the ring
//   (pid lookup, predecessor search, ready-slot search, free-slot search)
//   visits one slot at a time. The next input beat can be taken in the
//   cycle after the result is loaded. A new input beat is taken while a
//   finished result still waits on the output; the following result waits
//   for the output register to empty.
//   Reset clears all valid bits, the running slot, tick and task counts.
// ----------------------------------------------------------------------------
module priority_quantum_round_robin_scheduler
    import pqrr_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int PID_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [6:0]           cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2:0]           op,
    input  logic [PID_WIDTH-1:0] pid,
    input  logic [PID_WIDTH-1:0] parent_id,
    input  logic                 foreground,
    input  logic [2:0]           new_priority,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic [PID_WIDTH-1:0] running_pid,
    output logic [3:0]           running_slot,
    output logic                 switched
);

    localparam int SW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [CW-1:0] LAST_ITER = CW'(MAX_TASKS - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_TASKS);

    seq_state_t state_reg, state_next;
    logic [6:0]           aq_reg;
    logic [2:0]           mp_reg;
    logic [SW-1:0]        cur_reg, cur_next;
    logic [2:0]           tick_reg, tick_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [SW-1:0]        ptr_reg, ptr_next;
    logic [SW-1:0]        prev_reg, prev_next;
    logic [SW-1:0]        found_reg, found_next;
    logic [SW-1:0]        tmp_reg, tmp_next;
    logic [CW-1:0]        iter_reg, iter_next;
    logic                 curv_reg, curv_next;
    logic [2:0]           sts_reg, sts_next;
    logic                 sw_reg, sw_next;
    logic [2:0]           op_reg;
    logic [PID_WIDTH-1:0] pid_reg;
    logic [PID_WIDTH-1:0] parent_reg;
    logic                 fg_reg;
    logic [2:0]           np_reg;
    logic [PID_WIDTH-1:0] key_reg, key_next;
    logic                 out_valid_reg;
    logic [2:0]           out_sts_reg;
    logic [PID_WIDTH-1:0] out_pid_reg;
    logic [3:0]           out_slot_reg;
    logic                 out_sw_reg;
    logic                 load_out;

    slot_wr_t             we;
    logic [1:0]           wr_state;
    logic [2:0]           wr_prio;
    logic [6:0]           wr_turns;
    logic [SW-1:0]        wr_next;
    logic                 rd_valid;
    logic [PID_WIDTH-1:0] rd_pid;
    logic [PID_WIDTH-1:0] rd_parent;
    logic [1:0]           rd_state;
    logic [2:0]           rd_prio;
    logic [6:0]           rd_turns;
    logic [SW-1:0]        rd_next;
    logic [6:0]           turns_inc;
    logic                 accept;

    pqrr_slot_table #(
        .MAX_TASKS (MAX_TASKS),
        .PID_WIDTH (PID_WIDTH)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .addr      (ptr_reg),
        .we        (we),
        .wr_pid    (pid_reg),
        .wr_parent (parent_reg),
        .wr_state  (wr_state),
        .wr_prio   (wr_prio),
        .wr_turns  (wr_turns),
        .wr_next   (wr_next),
        .rd_valid  (rd_valid),
        .rd_pid    (rd_pid),
        .rd_parent (rd_parent),
        .rd_state  (rd_state),
        .rd_prio   (rd_prio),
        .rd_turns  (rd_turns),
        .rd_next   (rd_next)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign turns_inc = rd_turns + 7'd1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aq_reg <= 7'(AGING_RESET);
            mp_reg <= 3'(MAXPRI_RESET);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_AGING:  aq_reg <= cfg_wdata;
                CFG_MAXPRI: mp_reg <= cfg_wdata[2:0];
                default:    aq_reg <= aq_reg;
            endcase
        end
    end

    // sequencer and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_reg   <= '0;
            tick_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            tick_reg  <= tick_next;
            count_reg <= count_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        prev_reg  <= prev_next;
        found_reg <= found_next;
        tmp_reg   <= tmp_next;
        iter_reg  <= iter_next;
        curv_reg  <= curv_next;
        sts_reg   <= sts_next;
        sw_reg    <= sw_next;
        key_reg   <= key_next;
        if (accept)
        begin
            op_reg     <= op;
            pid_reg    <= pid;
            parent_reg <= parent_id;
            fg_reg     <= foreground;
            np_reg     <= new_priority;
        end
    end

    // next state, table writes
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        tick_next  = tick_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        prev_next  = prev_reg;
        found_next = found_reg;
        tmp_next   = tmp_reg;
        iter_next  = iter_reg;
        curv_next  = curv_reg;
        sts_next   = sts_reg;
        sw_next    = sw_reg;
        key_next   = key_reg;
        we         = '0;
        wr_state   = RS_READY;
        wr_prio    = 3'd0;
        wr_turns   = 7'd0;
        wr_next    = rd_next;
        load_out   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sts_next  = STS_OK;
                    sw_next   = 1'b0;
                    ptr_next  = cur_reg;
                    prev_next = cur_reg;
                    iter_next = '0;
                    key_next  = pid;
                    state_next = S_FIN;
                    case (op)
                        OP_TICK:
                        begin
                            if (count_reg == '0) sts_next = STS_NOREADY;
                            else state_next = S_TICK;
                        end
                        OP_ADD:
                        begin
                            if (count_reg >= FULL_COUNT)
                            begin
                                sts_next = STS_FULL;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_FREE;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (count_reg == '0) sts_next = STS_NOREADY;
                            else state_next = S_STEP;
                        end
                        OP_TOGGLE:
                        begin
                            if (count_reg == '0) sts_next = STS_NOREADY;
                            else state_next = S_FIND;
                        end
                        OP_SETPRI:
                        begin
                            if (new_priority > mp_reg) sts_next = STS_BADPRI;
                            else if (count_reg == '0) sts_next = STS_NOREADY;
                            else state_next = S_FIND;
                        end
                        OP_EXIT:
                        begin
                            if (count_reg == '0) sts_next = STS_NOREADY;
                            else state_next = S_XPAR;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            // count a tick or end the turn
            S_TICK:
            begin
                if (tick_reg < rd_prio)
                begin
                    tick_next  = tick_reg + 3'd1;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_AGE;
                end
            end

            // end the turn of the current slot: age it, drop it to ready
            S_AGE:
            begin
                tick_next = '0;
                curv_next = rd_valid;
                if (rd_valid)
                begin
                    if (rd_pid != '0)
                    begin
                        we.turns = 1'b1;
                        wr_turns = turns_inc;
                        if (turns_inc >= aq_reg)
                        begin
                            wr_turns = 7'd0;
                            if (rd_prio < mp_reg)
                            begin
                                we.prio = 1'b1;
                                wr_prio = rd_prio + 3'd1;
                            end
                        end
                    end
                    if (rd_state == RS_RUNNING)
                    begin
                        we.state = 1'b1;
                        wr_state = RS_READY;
                    end
                end
                ptr_next   = rd_next;
                iter_next  = '0;
                state_next = S_SCAN;
            end

            // walk the ring for the next ready slot
            S_SCAN:
            begin
                if (!rd_valid)
                begin
                    sts_next   = STS_NOREADY;
                    state_next = S_FIN;
                end
                else if (rd_state == RS_READY)
                begin
                    we.state = 1'b1;
                    wr_state = RS_RUNNING;
                    if (ptr_reg != cur_reg || !curv_reg) sw_next = 1'b1;
                    cur_next   = ptr_reg;
                    sts_next   = STS_OK;
                    state_next = S_FIN;
                end
                else if (iter_reg == LAST_ITER)
                begin
                    sts_next   = STS_NOREADY;
                    state_next = S_FIN;
                end
                else
                begin
                    ptr_next  = rd_next;
                    iter_next = iter_reg + 1'b1;
                end
            end

            // advance to the slot after the current one, then search
            S_STEP:
            begin
                ptr_next   = rd_next;
                state_next = S_FIND;
            end

            // search the ring for key_reg over task_count slots
            S_FIND:
            begin
                if (iter_reg == count_reg)
                begin
                    if (op_reg == OP_EXIT)
                    begin
                        ptr_next   = cur_reg;
                        prev_next  = cur_reg;
                        iter_next  = '0;
                        state_next = S_XPRED;
                    end
                    else
                    begin
                        sts_next   = STS_NOTFOUND;
                        state_next = S_FIN;
                    end
                end
                else if (rd_valid && rd_pid == key_reg)
                begin
                    case (op_reg)
                        OP_REMOVE:
                        begin
                            found_next   = ptr_reg;
                            tmp_next     = rd_next;
                            we.clr_valid = 1'b1;
                            count_next   = count_reg - 1'b1;
                            ptr_next     = prev_reg;
                            state_next   = S_UNLINK;
                        end
                        OP_TOGGLE:
                        begin
                            we.state = 1'b1;
                            wr_state = (rd_state == RS_BLOCKED) ? RS_READY : RS_BLOCKED;
                            state_next = (ptr_reg == cur_reg) ? S_AGE : S_FIN;
                        end
                        OP_SETPRI:
                        begin
                            we.prio    = 1'b1;
                            wr_prio    = np_reg;
                            we.turns   = 1'b1;
                            wr_turns   = 7'd0;
                            state_next = S_FIN;
                        end
                        default:
                        begin
                            // exit: wake the parent
                            we.state   = 1'b1;
                            wr_state   = RS_READY;
                            ptr_next   = cur_reg;
                            prev_next  = cur_reg;
                            iter_next  = '0;
                            state_next = S_XPRED;
                        end
                    endcase
                end
                else
                begin
                    prev_next = ptr_reg;
                    ptr_next  = rd_next;
                    iter_next = iter_reg + 1'b1;
                end
            end

            // relink the predecessor of a removed slot
            S_UNLINK:
            begin
                we.next  = 1'b1;
                wr_next  = tmp_reg;
                ptr_next = cur_reg;
                state_next = (found_reg == cur_reg) ? S_AGE : S_FIN;
            end

            // exit: read the parent of the current slot
            S_XPAR:
            begin
                key_next  = rd_parent;
                prev_next = cur_reg;
                iter_next = '0;
                if (rd_parent != '0)
                begin
                    state_next = S_STEP;
                end
                else
                begin
                    state_next = S_XPRED;
                end
            end

            // exit: find the slot whose link points at the current one
            S_XPRED:
            begin
                if (rd_next == cur_reg)
                begin
                    prev_next  = ptr_reg;
                    ptr_next   = cur_reg;
                    state_next = S_XRD;
                end
                else if (iter_reg == LAST_ITER)
                begin
                    ptr_next   = cur_reg;
                    state_next = S_XRD;
                end
                else
                begin
                    ptr_next  = rd_next;
                    iter_next = iter_reg + 1'b1;
                end
            end

            // exit: drop the current slot
            S_XRD:
            begin
                tmp_next     = rd_next;
                we.clr_valid = 1'b1;
                if (count_reg != '0) count_next = count_reg - 1'b1;
                ptr_next     = prev_reg;
                state_next   = S_XUNL;
            end

            S_XUNL:
            begin
                we.next    = 1'b1;
                wr_next    = tmp_reg;
                ptr_next   = cur_reg;
                state_next = S_AGE;
            end

            // add: find the lowest free slot and fill it
            S_FREE:
            begin
                if (!rd_valid)
                begin
                    we.pid       = 1'b1;
                    we.parent    = 1'b1;
                    we.prio      = 1'b1;
                    wr_prio      = 3'd0;
                    we.turns     = 1'b1;
                    wr_turns     = 7'd0;
                    we.set_valid = 1'b1;
                    we.state     = 1'b1;
                    count_next   = count_reg + 1'b1;
                    found_next   = ptr_reg;
                    if (count_reg == '0)
                    begin
                        we.next    = 1'b1;
                        wr_next    = ptr_reg;
                        wr_state   = RS_RUNNING;
                        cur_next   = ptr_reg;
                        sw_next    = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        wr_state   = RS_READY;
                        ptr_next   = cur_reg;
                        state_next = S_ADDRC;
                    end
                end
                else if (iter_reg == LAST_ITER)
                begin
                    sts_next   = STS_FULL;
                    state_next = S_FIN;
                end
                else
                begin
                    ptr_next  = ptr_reg + 1'b1;
                    iter_next = iter_reg + 1'b1;
                end
            end

            // add: take the current link
            S_ADDRC:
            begin
                tmp_next   = rd_next;
                ptr_next   = found_reg;
                state_next = S_ADDRS;
            end

            S_ADDRS:
            begin
                we.next    = 1'b1;
                wr_next    = tmp_reg;
                ptr_next   = cur_reg;
                state_next = S_ADDWC;
            end

            // add: link the new slot after current, block on foreground
            S_ADDWC:
            begin
                we.next = 1'b1;
                wr_next = found_reg;
                if (fg_reg && pid_reg != PID_WIDTH'(1))
                begin
                    we.state   = 1'b1;
                    wr_state   = RS_BLOCKED;
                    state_next = S_AGE;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            // hand the result to the output register
            S_FIN:
            begin
                ptr_next = cur_reg;
                if (ptr_reg == cur_reg && !(out_valid_reg && out_stall))
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_sts_reg  <= sts_reg;
            out_pid_reg  <= rd_valid ? rd_pid : '0;
            out_slot_reg <= 4'(cur_reg);
            out_sw_reg   <= sw_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_sts_reg;
    assign running_pid  = out_pid_reg;
    assign running_slot = out_slot_reg;
    assign switched     = out_sw_reg;

`ifndef ASSERT_OFF
    // task count never exceeds the table
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("task count above table size");

    // an accepted beat keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("input not stalled after accept");

    // a switch is reported only with status ok
    a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!switched || status == STS_OK))
        else $error("switch reported with error status");
`endif

endmodule

// ===== src/pqrr_slot_table.sv =====
// ----------------------------------------------------------------------------
// pqrr_slot_table: process slot storage
// One address port: every field is read and written at the same slot.
// Valid bits clear at reset; the other fields hold whatever was written.
// ----------------------------------------------------------------------------
module pqrr_slot_table
    import pqrr_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int PID_WIDTH = 16,
    localparam int SW = $clog2(MAX_TASKS)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [SW-1:0]        addr,
    input  slot_wr_t             we,
    input  logic [PID_WIDTH-1:0] wr_pid,
    input  logic [PID_WIDTH-1:0] wr_parent,
    input  logic [1:0]           wr_state,
    input  logic [2:0]           wr_prio,
    input  logic [6:0]           wr_turns,
    input  logic [SW-1:0]        wr_next,
    output logic                 rd_valid,
    output logic [PID_WIDTH-1:0] rd_pid,
    output logic [PID_WIDTH-1:0] rd_parent,
    output logic [1:0]           rd_state,
    output logic [2:0]           rd_prio,
    output logic [6:0]           rd_turns,
    output logic [SW-1:0]        rd_next
);

    logic [MAX_TASKS-1:0] valid_reg;
    logic [PID_WIDTH-1:0] pid_mem    [MAX_TASKS];
    logic [PID_WIDTH-1:0] parent_mem [MAX_TASKS];
    logic [1:0]           state_mem  [MAX_TASKS];
    logic [2:0]           prio_mem   [MAX_TASKS];
    logic [6:0]           turns_mem  [MAX_TASKS];
    logic [SW-1:0]        next_mem   [MAX_TASKS];

    // set or drop the valid bit of the addressed slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we.set_valid)
        begin
            valid_reg[addr] <= 1'b1;
        end
        else if (we.clr_valid)
        begin
            valid_reg[addr] <= 1'b0;
        end
    end

    // write slot fields
    always_ff @(posedge clk)
    begin
        if (we.pid)
        begin
            pid_mem[addr] <= wr_pid;
        end
        if (we.parent)
        begin
            parent_mem[addr] <= wr_parent;
        end
        if (we.state)
        begin
            state_mem[addr] <= wr_state;
        end
        if (we.prio)
        begin
            prio_mem[addr] <= wr_prio;
        end
        if (we.turns)
        begin
            turns_mem[addr] <= wr_turns;
        end
        if (we.next)
        begin
            next_mem[addr] <= wr_next;
        end
    end

    assign rd_valid  = valid_reg[addr];
    assign rd_pid    = pid_mem[addr];
    assign rd_parent = parent_mem[addr];
    assign rd_state  = state_mem[addr];
    assign rd_prio   = prio_mem[addr];
    assign rd_turns  = turns_mem[addr];
    assign rd_next   = next_mem[addr];

endmodule

// ===== test/priority_quantum_round_robin_scheduler_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_quantum_round_robin_scheduler_tb: self-checking bench of the
// round-robin scheduler
// Drives directed and random scheduling operations with random gaps and
// output stalls over several register settings. A scoreboard class keeps its
// own copy of the slot ring, predicts each result beat and checks every
// returned beat in order.
// ----------------------------------------------------------------------------
module priority_quantum_round_robin_scheduler_tb;
    import pqrr_pkg::*;

    localparam int NSLOTS = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_PER_PHASE = 215;
    localparam logic [2:0] OP_UNUSED_A = 3'd6;
    localparam logic [2:0] OP_UNUSED_B = 3'd7;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] running_pid;
        logic [3:0]  running_slot;
        logic        switched;
    } sched_result_t;

    class sched_scoreboard;
        int unsigned aging_quanta;
        int unsigned max_prio;
        bit          used [NSLOTS];
        bit [15:0]   task_pid [NSLOTS];
        bit [15:0]   task_parent [NSLOTS];
        logic [1:0]  run_state [NSLOTS];
        int unsigned prio [NSLOTS];
        int unsigned turns [NSLOTS];
        int unsigned link [NSLOTS];
        int unsigned cur_slot;
        int unsigned ticks;
        int unsigned ntasks;
        sched_result_t expected_beats [$];
        int errors;

        function new();
            aging_quanta = AGING_RESET;
            max_prio = MAXPRI_RESET;
            for (int i = 0; i < NSLOTS; i++)
            begin
                used[i] = 0;
                task_pid[i] = 0;
                task_parent[i] = 0;
                run_state[i] = RS_READY;
                prio[i] = 0;
                turns[i] = 0;
                link[i] = 0;
            end
            cur_slot = 0;
            ticks = 0;
            ntasks = 0;
            errors = 0;
        endfunction

        function void write_reg(logic idx, logic [6:0] value);
            if (idx == CFG_AGING)
                aging_quanta = value;
            else
                max_prio = value[2:0];
        endfunction

        // walk ntasks slots from start; -1 when the pid is absent
        function int lookup(int unsigned start, int unsigned pred, bit [15:0] p,
                            output int unsigned prev);
            int unsigned s;
            int unsigned q;
            s = start;
            q = pred;
            prev = 0;
            for (int i = 0; i < ntasks; i++)
            begin
                if (used[s] && task_pid[s] == p)
                begin
                    prev = q;
                    return s;
                end
                q = s;
                s = link[s];
            end
            return -1;
        endfunction

        function void unlink(int unsigned s, int unsigned prev);
            link[prev] = link[s];
            used[s] = 0;
            if (ntasks > 0)
                ntasks--;
        endfunction

        // close the running turn, age it, and pick the next ready slot
        function logic [2:0] rotate(inout bit sw);
            int unsigned c;
            int unsigned s;
            c = cur_slot;
            ticks = 0;
            if (used[c])
            begin
                if (task_pid[c] != 0)
                begin
                    turns[c] = (turns[c] + 1) & 7'h7f;
                    if (turns[c] >= aging_quanta)
                    begin
                        if (prio[c] < max_prio)
                            prio[c]++;
                        turns[c] = 0;
                    end
                end
                if (run_state[c] == RS_RUNNING)
                    run_state[c] = RS_READY;
            end
            s = link[c];
            for (int i = 0; i < NSLOTS; i++)
            begin
                if (!used[s])
                    break;
                if (run_state[s] == RS_READY)
                begin
                    run_state[s] = RS_RUNNING;
                    if (s != c || !used[c])
                        sw = 1;
                    cur_slot = s;
                    return STS_OK;
                end
                s = link[s];
            end
            return STS_NOREADY;
        endfunction

        // predict the result beat of one accepted operation
        function void note_op(logic [2:0] op, bit [15:0] p, bit [15:0] par, bit fg,
                              logic [2:0] np);
            logic [2:0] sts;
            bit sw;
            int unsigned c;
            int unsigned prev;
            int unsigned s;
            int f;
            sched_result_t r;
            sts = STS_OK;
            sw = 0;
            c = cur_slot;
            prev = 0;
            if ((op == OP_TICK || op == OP_REMOVE || op == OP_TOGGLE || op == OP_EXIT)
                && ntasks == 0)
                sts = STS_NOREADY;
            else if (op == OP_TICK)
            begin
                if (ticks < prio[c])
                    ticks = (ticks + 1) & 7;
                else
                    sts = rotate(sw);
            end
            else if (op == OP_ADD)
            begin
                for (s = 0; s < NSLOTS && used[s]; s++)
                begin
                end
                if (ntasks >= NSLOTS || s >= NSLOTS)
                    sts = STS_FULL;
                else
                begin
                    used[s] = 1;
                    task_pid[s] = p;
                    task_parent[s] = par;
                    prio[s] = 0;
                    turns[s] = 0;
                    ntasks++;
                    if (ntasks == 1)
                    begin
                        link[s] = s;
                        run_state[s] = RS_RUNNING;
                        cur_slot = s;
                        sw = 1;
                    end
                    else
                    begin
                        run_state[s] = RS_READY;
                        link[s] = link[c];
                        link[c] = s;
                        if (fg && p != 1)
                        begin
                            run_state[c] = RS_BLOCKED;
                            sts = rotate(sw);
                        end
                    end
                end
            end
            else if (op == OP_REMOVE)
            begin
                f = lookup(link[c], c, p, prev);
                if (f < 0)
                    sts = STS_NOTFOUND;
                else
                begin
                    unlink(f, prev);
                    if (f == c)
                        sts = rotate(sw);
                end
            end
            else if (op == OP_TOGGLE)
            begin
                f = lookup(c, c, p, prev);
                if (f < 0)
                    sts = STS_NOTFOUND;
                else
                begin
                    run_state[f] = (run_state[f] == RS_BLOCKED) ? RS_READY : RS_BLOCKED;
                    if (f == c)
                        sts = rotate(sw);
                end
            end
            else if (op == OP_SETPRI)
            begin
                if (np > max_prio)
                    sts = STS_BADPRI;
                else if (ntasks == 0)
                    sts = STS_NOREADY;
                else
                begin
                    f = lookup(c, c, p, prev);
                    if (f < 0)
                        sts = STS_NOTFOUND;
                    else
                    begin
                        prio[f] = np;
                        turns[f] = 0;
                    end
                end
            end
            else if (op == OP_EXIT)
            begin
                // wake the parent, then drop self from the ring
                if (task_parent[c] != 0)
                begin
                    f = lookup(link[c], c, task_parent[c], prev);
                    if (f >= 0)
                        run_state[f] = RS_READY;
                end
                prev = c;
                s = c;
                for (int i = 0; i < NSLOTS; i++)
                begin
                    if (link[s] == c)
                    begin
                        prev = s;
                        break;
                    end
                    s = link[s];
                end
                unlink(c, prev);
                sts = rotate(sw);
            end
            c = cur_slot;
            r.status = sts;
            r.running_pid = used[c] ? task_pid[c] : 16'd0;
            r.running_slot = c[3:0];
            r.switched = sw;
            expected_beats.push_back(r);
        endfunction

        function void check_result(sched_result_t got);
            sched_result_t want;
            if (expected_beats.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: %p", got);
                return;
            end
            want = expected_beats.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected sts=%0d pid=%0d slot=%0d sw=%0d, ",
                              "got sts=%0d pid=%0d slot=%0d sw=%0d"},
                             want.status, want.running_pid, want.running_slot,
                             want.switched, got.status, got.running_pid,
                             got.running_slot, got.switched);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [6:0]  cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  op;
    logic [15:0] pid;
    logic [15:0] parent_id;
    logic        foreground;
    logic [2:0]  new_priority;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [15:0] running_pid;
    logic [3:0]  running_slot;
    logic        switched;

    sched_scoreboard sb;
    bit quiet;
    int stall_left;
    int idle_cycles;

    priority_quantum_round_robin_scheduler DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .pid(pid), .parent_id(parent_id),
        .foreground(foreground), .new_priority(new_priority),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .running_pid(running_pid),
        .running_slot(running_slot), .switched(switched)
    );

    initial
    begin
        clk = 0;
    end

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // track accepted beats on both channels, and the watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_op(op, pid, parent_id, foreground, new_priority);
            if (out_valid && !out_stall)
                sb.check_result({status, running_pid, running_slot, switched});
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // random output stalls
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    task automatic send_op(logic [2:0] o, logic [15:0] p, logic [15:0] par, logic fg,
                           logic [2:0] np);
        int gap;
        gap = (quiet || $urandom_range(0, 9) < 7) ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        op <= o;
        pid <= p;
        parent_id <= par;
        foreground <= fg;
        new_priority <= np;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic go_idle();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // hold the sender until every result is back, then let the block settle
    task automatic drain();
        go_idle();
        while (sb.expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        sb.write_reg(idx, value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [15:0] pick_pid();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 16'($urandom_range(0, 65535));
        if (r == 1)
            return 16'd0;
        return 16'($urandom_range(1, 12));
    endfunction

    task automatic random_op();
        int r;
        logic [2:0] o;
        logic [15:0] par;
        r = $urandom_range(0, 99);
        if (r < 40)
            o = OP_TICK;
        else if (r < 58)
            o = OP_ADD;
        else if (r < 68)
            o = OP_REMOVE;
        else if (r < 80)
            o = OP_TOGGLE;
        else if (r < 90)
            o = OP_SETPRI;
        else if (r < 96)
            o = OP_EXIT;
        else
            o = (r < 98) ? OP_UNUSED_A : OP_UNUSED_B;
        r = $urandom_range(0, 9);
        par = (r < 5) ? 16'd0 : (r < 9) ? pick_pid() : 16'($urandom_range(0, 65535));
        send_op(o, pick_pid(), par, 1'($urandom_range(0, 1)),
                3'($urandom_range(0, 7)));
    endtask

    initial
    begin
        int aging_set [6];
        int maxpri_set [6];
        sb = new();
        quiet = 0;
        stall_left = 0;
        idle_cycles = 0;
        rst_n = 0;
        cfg_wr_en = 0;
        cfg_index = CFG_AGING;
        cfg_wdata = 0;
        in_valid = 0;
        op = OP_TICK;
        pid = 0;
        parent_id = 0;
        foreground = 0;
        new_priority = 0;
        out_stall = 0;
        aging_set = '{1, 127, 90, 2, 0, 5};
        maxpri_set = '{0, 7, 5, 3, 0, 7};
        aging_set[4] = $urandom_range(1, 127);
        maxpri_set[4] = $urandom_range(0, 7);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: empty table, priorities, adds, foreground, ticks, toggles, remove, exit, unknown ops
        send_op(OP_TICK, 16'd5, 16'd0, 1'b0, 3'd0);
        send_op(OP_REMOVE, 16'd5, 16'd0, 1'b0, 3'd0);
        send_op(OP_TOGGLE, 16'd5, 16'd0, 1'b0, 3'd0);
        send_op(OP_EXIT, 16'd0, 16'd0, 1'b0, 3'd0);
        send_op(OP_SETPRI, 16'd5, 16'd0, 1'b0, 3'd7);
        send_op(OP_SETPRI, 16'd5, 16'd0, 1'b0, 3'd2);
        send_op(OP_ADD, 16'd1, 16'd0, 1'b0, 3'd0);
        send_op(OP_ADD, 16'hffff, 16'd1, 1'b1, 3'd0);
        send_op(OP_ADD, 16'd0, 16'hffff, 1'b0, 3'd0);
        send_op(OP_ADD, 16'd1, 16'd0, 1'b1, 3'd0);
        send_op(OP_SETPRI, 16'hffff, 16'd0, 1'b0, 3'd5);
        send_op(OP_SETPRI, 16'd0, 16'd0, 1'b0, 3'd6);
        send_op(OP_TICK, 16'd0, 16'd0, 1'b0, 3'd0);
        send_op(OP_TICK, 16'd0, 16'd0, 1'b0, 3'd0);
        send_op(OP_TOGGLE, 16'd1, 16'd0, 1'b0, 3'd0);
        send_op(OP_TOGGLE, 16'd7, 16'd0, 1'b0, 3'd0);
        send_op(OP_REMOVE, 16'd9, 16'd0, 1'b0, 3'd0);
        send_op(OP_EXIT, 16'd0, 16'd0, 1'b0, 3'd0);
        send_op(OP_UNUSED_A, 16'd1, 16'd1, 1'b1, 3'd7);
        send_op(OP_UNUSED_B, 16'd1, 16'd1, 1'b1, 3'd7);
        send_op(OP_REMOVE, 16'd1, 16'd0, 1'b0, 3'd0);
        send_op(OP_TICK, 16'd0, 16'd0, 1'b0, 3'd0);
        send_op(OP_EXIT, 16'd0, 16'd0, 1'b0, 3'd0);
        drain();

        // random phases, each under its own register setting
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_AGING, 7'(aging_set[ph]));
            write_reg(CFG_MAXPRI, 7'(maxpri_set[ph]));
            quiet = (ph == 2);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                random_op();
            drain();
        end

        if (sb.errors == 0 && sb.expected_beats.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
